[rtl/tlidx_pkg.sv]
`default_nettype none

package tlidx_pkg;

    // field widths
    localparam int OFFSET_W = 48;
    localparam int NEXT_W   = 49;
    localparam int LEN_W    = 31;
    localparam int UNIT_W   = 32;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_UNIT_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_LANE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET    = 2'd2;

    // input commands
    localparam logic CMD_CODE_UNIT = 1'b0;
    localparam logic CMD_END       = 1'b1;

    // characters tested in the selected lane
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    // saturation limit of lengths and added spaces
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic              cmd;
        logic [UNIT_W-1:0] code_unit;
        logic [OFFSET_W-1:0] total_size;
    } item_t;

    typedef struct packed {
        logic [NEXT_W-1:0] next_line_offset;
        logic [LEN_W-1:0]  line_length;
        logic [LEN_W-1:0]  peak_length;
        logic              fake_final;
    } result_t;

endpackage

`default_nettype wire

[rtl/tlidx_core.sv]
`default_nettype none

module tlidx_core #(
    parameter int TAB_STOP = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlidx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlidx_pkg::CFG_W-1:0]      cfg_data,
    input  logic                             accept,
    input  tlidx_pkg::item_t                 item,
    output logic                             res_valid,
    output tlidx_pkg::result_t               res
);
    import tlidx_pkg::*;

    // column bookkeeping is kept modulo the tab stop
    localparam int MW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int SW    = $clog2(TAB_STOP + 7);
    localparam int STEPS = (TAB_STOP + 6) / TAB_STOP;
    localparam logic [MW-1:0] TAB_LAST = MW'(TAB_STOP - 1);
    localparam int SAT_MOD_INT = int'({1'b0, LEN_MAX}) % TAB_STOP;
    localparam logic [MW-1:0] SAT_MOD = MW'(SAT_MOD_INT);

    logic [2:0]          cuw_reg;
    logic [1:0]          lane_reg;
    logic [OFFSET_W-1:0] start_reg;

    logic                started_reg, started_next;
    logic [OFFSET_W-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_W-1:0] line_start_reg, line_start_next;
    logic [OFFSET_W-1:0] span_reg, span_next;
    logic [MW-1:0]       span_mod_reg, span_mod_next;
    logic [LEN_W-1:0]    extra_reg, extra_next;
    logic [MW-1:0]       extra_mod_reg, extra_mod_next;
    logic [LEN_W-1:0]    max_reg, max_next;

    logic [2:0]          width;
    logic [OFFSET_W-1:0] bo;
    logic [OFFSET_W-1:0] ls;
    logic [7:0]          ch;
    logic [NEXT_W-1:0]   next_off;
    logic [OFFSET_W:0]   len_sum;
    logic [LEN_W-1:0]    len;
    logic [MW:0]         col_sum;
    logic [MW-1:0]       col;
    logic [MW-1:0]       add;
    logic [LEN_W:0]      ext_sum;
    logic [SW-1:0]       adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cuw_reg   <= 3'd1;
            lane_reg  <= 2'd0;
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_UNIT_WIDTH: cuw_reg   <= cfg_data[2:0];
                REG_NEWLINE_LANE:    lane_reg  <= cfg_data[1:0];
                REG_START_OFFSET:    start_reg <= cfg_data[OFFSET_W-1:0];
                default:             ;
            endcase
        end
    end

    // operands of the current transaction
    always_comb
    begin
        width    = (cuw_reg == 3'd0) ? 3'd1 : cuw_reg;
        bo       = started_reg ? byte_offset_reg : start_reg;
        ls       = started_reg ? line_start_reg : start_reg;
        ch       = item.code_unit[{lane_reg, 3'b000} +: 8];
        next_off = {1'b0, bo} + NEXT_W'(width);
        len_sum  = {1'b0, span_reg} + (OFFSET_W + 1)'(extra_reg);
        len      = (len_sum > (OFFSET_W + 1)'(LEN_MAX)) ? LEN_MAX : len_sum[LEN_W-1:0];
        col_sum  = {1'b0, span_mod_reg} + {1'b0, extra_mod_reg};
        col      = (col_sum >= (MW + 1)'(TAB_STOP)) ?
                   MW'(col_sum - (MW + 1)'(TAB_STOP)) : col_sum[MW-1:0];
        add      = TAB_LAST - col;
        ext_sum  = {1'b0, extra_reg} + (LEN_W + 1)'(add);
    end

    // span modulo the tab stop after this code unit
    always_comb
    begin
        adv = SW'(span_mod_reg) + SW'(width);
        for (int i = 0; i < STEPS; i++)
        begin
            if (adv >= SW'(TAB_STOP))
                adv = adv - SW'(TAB_STOP);
        end
    end

    // state update and result
    always_comb
    begin
        started_next     = started_reg;
        byte_offset_next = byte_offset_reg;
        line_start_next  = line_start_reg;
        span_next        = span_reg;
        span_mod_next    = span_mod_reg;
        extra_next       = extra_reg;
        extra_mod_next   = extra_mod_reg;
        max_next         = max_reg;
        res_valid        = 1'b0;
        res.next_line_offset = next_off;
        res.line_length      = len;
        res.peak_length      = max_reg;
        res.fake_final       = 1'b0;

        if (accept)
        begin
            started_next     = 1'b1;
            byte_offset_next = bo;
            line_start_next  = ls;
            if (item.cmd == CMD_END)
            begin
                res.next_line_offset = NEXT_W'(item.total_size) + NEXT_W'(1);
                res.line_length      = '0;
                res.fake_final       = 1'b1;
                res_valid            = (item.total_size > ls);
            end
            else
            begin
                byte_offset_next = next_off[OFFSET_W-1:0];
                span_next        = span_reg + OFFSET_W'(width);
                span_mod_next    = MW'(adv);
                if (ch == CH_NL)
                begin
                    max_next        = (len > max_reg) ? len : max_reg;
                    res.peak_length = max_next;
                    res_valid       = 1'b1;
                    line_start_next = next_off[OFFSET_W-1:0];
                    span_next       = '0;
                    span_mod_next   = '0;
                    extra_next      = '0;
                    extra_mod_next  = '0;
                end
                else if (ch == CH_TAB)
                begin
                    if (ext_sum > (LEN_W + 1)'(LEN_MAX))
                    begin
                        extra_next     = LEN_MAX;
                        extra_mod_next = SAT_MOD;
                    end
                    else
                    begin
                        extra_next     = ext_sum[LEN_W-1:0];
                        extra_mod_next = TAB_LAST - span_mod_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            byte_offset_reg <= '0;
            line_start_reg  <= '0;
            span_reg        <= '0;
            span_mod_reg    <= '0;
            extra_reg       <= '0;
            extra_mod_reg   <= '0;
            max_reg         <= '0;
        end
        else
        begin
            started_reg     <= started_next;
            byte_offset_reg <= byte_offset_next;
            line_start_reg  <= line_start_next;
            span_reg        <= span_next;
            span_mod_reg    <= span_mod_next;
            extra_reg       <= extra_next;
            extra_mod_reg   <= extra_mod_next;
            max_reg         <= max_next;
        end
    end

endmodule

`default_nettype wire

[rtl/text_line_indexer_tab_expand_top.sv]
// channel   signals                                 direction
// item      item_valid, item_stall, item            in  (code unit or end of stream)
// result    result_valid, result_stall, result      out (line entry)
// config    cfg_we, cfg_index, cfg_data             in  (write only)
//
// one transaction per cycle in while item_stall is low; each result is registered in the output stage
// the rate is set by the combinational state update in the core
// results pass a two-entry output stage; item_stall rises only when both hold
// asynchronous active-low reset; start_offset loads on the first item after reset
`default_nettype none

module text_line_indexer_tab_expand_top #(
    parameter int TAB_STOP = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tlidx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlidx_pkg::CFG_W-1:0]      cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  tlidx_pkg::item_t                 item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output tlidx_pkg::result_t               result
);
    import tlidx_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_free;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    tlidx_core #(
        .TAB_STOP (TAB_STOP)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // output register with skid entry
    always_comb
    begin
        out_free        = !out_valid_reg || !result_stall;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

[rtl/tlidx_checker.sv]
`default_nettype none

module tlidx_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input tlidx_pkg::result_t  result
);
    import tlidx_pkg::*;

    // a stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input stall only while a result waits
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item stalled with empty output");

    // the skid entry fills only behind a held result
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_stall) |-> $past(result_valid && result_stall && item_valid))
        else $error("item stall rose without a held result");

    // fake final entries carry no length
    a_fake_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fake_final |-> result.line_length == '0)
        else $error("fake final entry with nonzero length");

    // the running maximum covers the reported line
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fake_final |-> result.line_length <= result.peak_length)
        else $error("line length above running maximum");

endmodule

bind text_line_indexer_tab_expand_top tlidx_checker u_checker (.*);

`default_nettype wire

[tb/line_index_checker.sv]
`default_nettype none

module line_index_checker #(
    parameter int TAB_STOP = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tlidx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlidx_pkg::CFG_W-1:0]    cfg_data,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  tlidx_pkg::item_t               item,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  tlidx_pkg::result_t             result,
    output int                             mismatch_count,
    output int                             pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import tlidx_pkg::*;

    // register copies
    logic [2:0]          unit_width_cfg;
    logic [1:0]          lane_cfg;
    logic [OFFSET_W-1:0] start_cfg;

    // indexer state
    bit                  started;
    logic [OFFSET_W-1:0] byte_pos;
    logic [OFFSET_W-1:0] line_begin;
    logic [LEN_W-1:0]    added_spaces;
    logic [LEN_W-1:0]    longest_line;

    result_t             expected_entries[$];
    int                  errors;

    function automatic logic [LEN_W-1:0] clamp_len(logic [63:0] v);
        return (v > 64'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
    endfunction

    // advance the line index by one item, queue the entry it produces
    function void index_item(item_t it);
        logic [63:0]         step_bytes;
        logic [7:0]          ch;
        logic [OFFSET_W-1:0] span48;
        logic [63:0]         span;
        logic [63:0]         col;
        logic [NEXT_W-1:0]   next_start;
        logic [LEN_W-1:0]    len;
        result_t             entry;
        step_bytes = (unit_width_cfg == 3'd0) ? 64'd1 : 64'(unit_width_cfg);
        if (!started)
        begin
            byte_pos   = start_cfg;
            line_begin = start_cfg;
            started    = 1'b1;
        end
        // end of stream: fake entry for an unterminated last line, state untouched
        if (it.cmd == CMD_END)
        begin
            if (it.total_size > line_begin)
            begin
                entry.next_line_offset = {1'b0, it.total_size} + 49'd1;
                entry.line_length      = '0;
                entry.peak_length      = longest_line;
                entry.fake_final       = 1'b1;
                expected_entries.push_back(entry);
            end
            return;
        end
        ch     = it.code_unit[8*lane_cfg +: 8];
        span48 = byte_pos - line_begin;
        span   = 64'(span48);
        if (ch == CH_NL)
        begin
            len        = clamp_len(span + 64'(added_spaces));
            next_start = {1'b0, byte_pos} + step_bytes[NEXT_W-1:0];
            if (len > longest_line)
                longest_line = len;
            line_begin   = next_start[OFFSET_W-1:0];
            added_spaces = '0;
            entry.next_line_offset = next_start;
            entry.line_length      = len;
            entry.peak_length      = longest_line;
            entry.fake_final       = 1'b0;
            expected_entries.push_back(entry);
        end
        else if (ch == CH_TAB)
        begin
            // column counts bytes plus spaces already added
            col = (span + 64'(added_spaces)) % 64'(TAB_STOP);
            added_spaces = clamp_len(64'(added_spaces) + 64'(TAB_STOP) - col - 64'd1);
        end
        byte_pos = byte_pos + step_bytes[OFFSET_W-1:0];
    endfunction

    // compare one line entry against the oldest expected one
    function void check_entry(result_t got);
        result_t want;
        bit      bad;
        if (expected_entries.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected line entry: next=%h len=%0d max=%0d fake=%0b",
                         got.next_line_offset, got.line_length, got.peak_length,
                         got.fake_final);
            return;
        end
        want = expected_entries.pop_front();
        bad  = 1'b0;
        if (got.next_line_offset !== want.next_line_offset)
            bad = 1'b1;
        if (got.line_length !== want.line_length)
            bad = 1'b1;
        if (got.peak_length !== want.peak_length)
            bad = 1'b1;
        if (got.fake_final !== want.fake_final)
            bad = 1'b1;
        if (bad)
        begin
            errors++;
            if (errors <= 10)
                $display("line entry mismatch: expected next=%h len=%0d max=%0d fake=%0b,",
                         want.next_line_offset, want.line_length, want.peak_length,
                         want.fake_final,
                         " got next=%h len=%0d max=%0d fake=%0b",
                         got.next_line_offset, got.line_length,
                         got.peak_length, got.fake_final);
        end
    endfunction

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_width_cfg = 3'd1;
            lane_cfg       = 2'd0;
            start_cfg      = '0;
            started        = 1'b0;
            byte_pos       = '0;
            line_begin     = '0;
            added_spaces   = '0;
            longest_line   = '0;
            expected_entries.delete();
            errors         = 0;
            mismatch_count <= 0;
            pending        <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_entry(result);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CODE_UNIT_WIDTH: unit_width_cfg = cfg_data[2:0];
                    REG_NEWLINE_LANE:    lane_cfg       = cfg_data[1:0];
                    REG_START_OFFSET:    start_cfg      = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                index_item(item);
            mismatch_count <= errors;
            pending        <= expected_entries.size();
        end
    end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tlidx_pkg::*;

    localparam int TAB_STOP = 8;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_CODE_UNIT_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;

    int                   fail_count;
    int                   pending;
    bit                   steady       = 1'b0;
    logic [1:0]           lane_now     = 2'd0;

    text_line_indexer_tab_expand_top #(
        .TAB_STOP(TAB_STOP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    line_index_checker #(
        .TAB_STOP(TAB_STOP)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .mismatch_count (fail_count),
        .pending        (pending)
    );

    always #10 clk = ~clk;

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("text_line_indexer_tab_expand_top test failed");
        $finish;
    end

    // result side: random stall before each transaction
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_NEWLINE_LANE)
            lane_now = data[1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // item side: random gap, then hold until accepted
    task automatic send_item(item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // wait for every expected line entry, then let the pipeline empty
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic item_t raw_unit(logic [31:0] u);
        item_t it;
        it.cmd        = CMD_CODE_UNIT;
        it.code_unit  = u;
        it.total_size[47:32] = 16'($urandom);
        it.total_size[31:0]  = $urandom;
        return it;
    endfunction

    // code unit with the tested character in the current lane
    function automatic item_t text_unit(logic [7:0] ch);
        item_t it;
        it = raw_unit($urandom);
        it.code_unit[8*lane_now +: 8] = ch;
        return it;
    endfunction

    function automatic item_t end_item(logic [OFFSET_W-1:0] total);
        item_t it;
        it.cmd        = CMD_END;
        it.code_unit  = $urandom;
        it.total_size = total;
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return CH_NL;
        else if (r < 30)
            return CH_TAB;
        else if (r < 85)
            return 8'($urandom_range(8'h20, 8'h7E));
        else
            return 8'($urandom);
    endfunction

    function automatic logic [OFFSET_W-1:0] pick_total();
        logic [OFFSET_W-1:0] t;
        case ($urandom_range(0, 3))
            0: t = 48'($urandom_range(0, 4000));
            1:
            begin
                t[47:32] = 16'($urandom);
                t[31:0]  = $urandom;
            end
            2: t = OFFSET_MAX - 48'($urandom_range(0, 4000));
            default: t = $urandom_range(0, 1) ? OFFSET_MAX : '0;
        endcase
        return t;
    endfunction

    // one stretch of random text under a random setting
    task automatic random_phase(int count);
        logic [CFG_W-1:0] data;
        logic [2:0]       width;
        data[47:32] = 16'($urandom);
        data[31:0]  = $urandom;
        case ($urandom_range(0, 11))
            0, 1:    width = 3'd1;
            2, 3:    width = 3'd2;
            4, 5:    width = 3'd4;
            6:       width = 3'd0;
            7:       width = 3'd3;
            8:       width = 3'd5;
            9:       width = 3'd6;
            10:      width = 3'd7;
            default: width = 3'd1;
        endcase
        data[2:0] = width;
        write_reg(REG_CODE_UNIT_WIDTH, data);
        data[47:32] = 16'($urandom);
        data[31:0]  = $urandom;
        write_reg(REG_NEWLINE_LANE, data);
        // start offset is only taken after reset, so this write must not matter
        if ($urandom_range(0, 2) == 0)
        begin
            data[47:32] = 16'($urandom);
            data[31:0]  = $urandom;
            write_reg(REG_START_OFFSET, data);
        end
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(end_item(pick_total()));
            else
                send_item(text_unit(pick_char()));
        end
        settle();
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // offsets start just below the 48-bit wrap
        write_reg(REG_CODE_UNIT_WIDTH, 48'd1);
        write_reg(REG_NEWLINE_LANE, 48'd0);
        write_reg(REG_START_OFFSET, OFFSET_MAX - 48'd9);
        send_item(end_item('0));
        send_item(text_unit(8'h41));
        send_item(text_unit(CH_TAB));
        send_item(raw_unit(32'hFFFF_FF09));
        send_item(raw_unit(32'h0A0A_0A0A));
        send_item(end_item(OFFSET_MAX));
        send_item(raw_unit(32'h0000_0000));
        send_item(raw_unit(32'hFFFF_FFFF));
        send_item(text_unit(CH_TAB));
        send_item(text_unit(CH_TAB));
        send_item(text_unit(8'h78));
        send_item(text_unit(CH_NL));
        send_item(end_item('0));
        send_item(end_item(48'd1));
        settle();

        // late start offset, widest lane, four-byte units
        write_reg(REG_START_OFFSET, OFFSET_MAX);
        write_reg(REG_CODE_UNIT_WIDTH, 48'd4);
        write_reg(REG_NEWLINE_LANE, 48'd3);
        send_item(raw_unit(32'h0900_0041));
        send_item(raw_unit(32'h0A00_0000));
        settle();

        // width zero acts as one, lane outside a one-byte unit
        write_reg(REG_CODE_UNIT_WIDTH, 48'd0);
        write_reg(REG_NEWLINE_LANE, 48'd2);
        send_item(raw_unit(32'h0009_000A));
        send_item(raw_unit(32'h000A_0000));
        settle();

        // odd width
        write_reg(REG_START_OFFSET, '0);
        write_reg(REG_CODE_UNIT_WIDTH, 48'd7);
        write_reg(REG_NEWLINE_LANE, 48'd1);
        send_item(raw_unit(32'h0000_0900));
        send_item(raw_unit(32'h0000_0A00));
        send_item(end_item(48'd100));
        settle();

        // random text, some phases without any idling
        for (int p = 0; p < 7; p++)
        begin
            steady = (p == 2 || p == 5);
            random_phase(200);
        end
        steady = 1'b0;

        if (fail_count == 0)
            $display("text_line_indexer_tab_expand_top test passed");
        else
            $display("text_line_indexer_tab_expand_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/tlidx_pkg.sv
rtl/tlidx_core.sv
rtl/text_line_indexer_tab_expand_top.sv
rtl/tlidx_checker.sv
tb/line_index_checker.sv
tb/tb.sv
